FILE: rtl/serpentine_panel_position_gen_assert.svh
`ifndef SERPENTINE_PANEL_POSITION_GEN_ASSERT_SVH
`define SERPENTINE_PANEL_POSITION_GEN_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SPPG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("serpentine_panel_position_gen: check failed");

// Next-cycle implication, checked out of reset
`define SPPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("serpentine_panel_position_gen: check failed");

`endif

FILE: rtl/spg_pkg.sv
package spg_pkg;

    localparam int COORD_W = 32;
    localparam int CAP_W   = 13;
    localparam int CNT_W   = 13;
    localparam int IDX_W   = 12;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;
    localparam logic [CNT_W-1:0] IDX_LIMIT = 13'd4095;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [CAP_W-1:0]          cap_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic [IDX_W-1:0]          idx_t;

    typedef struct packed {
        logic   first_panel;
        coord_t origin_x;
        coord_t origin_y;
        coord_t col_step_x;
        coord_t col_step_y;
        coord_t row_step_x;
        coord_t row_step_y;
    } desc_t;

    typedef struct packed {
        logic  valid;
        desc_t head;
    } qhead_t;

endpackage

FILE: rtl/spg_front.sv
`include "serpentine_panel_position_gen_assert.svh"

module spg_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  spg_pkg::desc_t in_desc,
    output spg_pkg::qhead_t q_head,
    input  logic           q_pop
);
    import spg_pkg::*;

    desc_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    logic               pop;

    assign in_stall = (count_reg == QCNT_W'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && (count_reg != '0);

    assign q_head.valid = (count_reg != '0);
    assign q_head.head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold the panel description until the generator takes it
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_desc;
        end
    end

    `SPPG_ASSERT_IMP(a_q_bound, 1'b1, count_reg <= QCNT_W'(QDEPTH))
    `SPPG_ASSERT_NEXT(a_q_fill, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

FILE: rtl/spg_back.sv
`include "serpentine_panel_position_gen_assert.svh"

module spg_back
#(
    parameter int PANEL_WIDTH  = 8,
    parameter int PANEL_HEIGHT = 8,
    parameter int MAX_LIGHTS   = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  spg_pkg::cap_t   cfg_wdata,
    input  spg_pkg::qhead_t q_head,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output spg_pkg::coord_t pos_x,
    output spg_pkg::coord_t pos_y,
    output spg_pkg::idx_t   light_index,
    output logic            dropped,
    output logic            last_of_panel
);
    import spg_pkg::*;

    localparam int CW = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
    localparam int RW = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
    localparam logic [CW-1:0]    COL_LAST = CW'(PANEL_WIDTH - 1);
    localparam logic [RW-1:0]    ROW_LAST = RW'(PANEL_HEIGHT - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LIGHTS);

    cap_t            cap_reg;
    logic            busy_reg;
    logic            busy_next;
    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_next;
    logic [RW-1:0]   row_reg;
    logic [RW-1:0]   row_next;
    cnt_t            cnt_reg;
    cnt_t            cnt_next;
    coord_t          cur_x_reg;
    coord_t          cur_x_next;
    coord_t          cur_y_reg;
    coord_t          cur_y_next;
    coord_t          ux_reg;
    coord_t          uy_reg;
    coord_t          vx_reg;
    coord_t          vy_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    coord_t          pos_x_reg;
    coord_t          pos_y_reg;
    idx_t            idx_reg;
    logic            drop_reg;
    logic            last_reg;
    logic            emit;
    logic            col_end;
    logic            is_last;
    logic            pop;
    cap_t            cap_eff;
    cnt_t            cnt_inc;

    assign emit    = busy_reg && (!out_valid_reg || !out_stall);
    assign col_end = (col_reg == COL_LAST);
    assign is_last = col_end && (row_reg == ROW_LAST);
    assign pop     = q_head.valid && (!busy_reg || (emit && is_last));
    assign q_pop   = pop;
    assign cap_eff = (cap_reg > CNT_MAX) ? CNT_MAX : cap_reg;
    assign cnt_inc = (cnt_reg < CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        cnt_next   = emit ? cnt_inc : cnt_reg;
        if (pop)
        begin
            busy_next  = 1'b1;
            col_next   = '0;
            row_next   = '0;
            cur_x_next = q_head.head.origin_x;
            cur_y_next = q_head.head.origin_y;
            if (q_head.head.first_panel)
            begin
                cnt_next = '0;
            end
        end
        else if (emit && is_last)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            if (col_end)
            begin
                // next row starts one row step away, whichever way this row ran
                col_next   = '0;
                row_next   = row_reg + 1'b1;
                cur_x_next = cur_x_reg + vx_reg;
                cur_y_next = cur_y_reg + vy_reg;
            end
            else if (row_reg[0])
            begin
                col_next   = col_reg + 1'b1;
                cur_x_next = cur_x_reg - ux_reg;
                cur_y_next = cur_y_reg - uy_reg;
            end
            else
            begin
                col_next   = col_reg + 1'b1;
                cur_x_next = cur_x_reg + ux_reg;
                cur_y_next = cur_y_reg + uy_reg;
            end
        end
        out_valid_next = emit ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            busy_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            busy_reg      <= busy_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ux_reg <= q_head.head.col_step_x;
            uy_reg <= q_head.head.col_step_y;
            vx_reg <= q_head.head.row_step_x;
            vy_reg <= q_head.head.row_step_y;
        end
        if (emit)
        begin
            pos_x_reg <= cur_x_reg;
            pos_y_reg <= cur_y_reg;
            idx_reg   <= (cnt_reg > IDX_LIMIT) ? IDX_LIMIT[IDX_W-1:0] : cnt_reg[IDX_W-1:0];
            drop_reg  <= (cnt_reg >= cap_eff);
            last_reg  <= is_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign light_index   = idx_reg;
    assign dropped       = drop_reg;
    assign last_of_panel = last_reg;

    `SPPG_ASSERT_IMP(a_cnt_sat, 1'b1, cnt_reg <= CNT_MAX)
    `SPPG_ASSERT_NEXT(a_chain, emit && is_last && q_head.valid, busy_reg && col_reg == '0)
    `SPPG_ASSERT_NEXT(a_row_wrap, emit && col_end && !is_last && !pop, col_reg == '0 && busy_reg)

endmodule

FILE: rtl/serpentine_panel_position_gen.sv
// Panels queue, then the single position accumulator walks each one in turn.
// Throughput: one light per cycle when not stalled, set by that accumulator;
//   PANEL_WIDTH*PANEL_HEIGHT lights per panel; panels chain without a gap.
// Input side takes up to two panels ahead through a two-entry queue.
// Reset: queue empty, generator idle, light index 0, light_capacity 4096.
module serpentine_panel_position_gen
#(
    parameter int PANEL_WIDTH  = 8,
    parameter int PANEL_HEIGHT = 8,
    parameter int MAX_LIGHTS   = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  spg_pkg::cap_t   cfg_wdata,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            first_panel,
    input  spg_pkg::coord_t origin_x,
    input  spg_pkg::coord_t origin_y,
    input  spg_pkg::coord_t col_step_x,
    input  spg_pkg::coord_t col_step_y,
    input  spg_pkg::coord_t row_step_x,
    input  spg_pkg::coord_t row_step_y,
    output logic            out_valid,
    input  logic            out_stall,
    output spg_pkg::coord_t pos_x,
    output spg_pkg::coord_t pos_y,
    output spg_pkg::idx_t   light_index,
    output logic            dropped,
    output logic            last_of_panel
);
    import spg_pkg::*;

    desc_t  in_desc;
    qhead_t q_head;
    logic   q_pop;

    always_comb
    begin
        in_desc.first_panel = first_panel;
        in_desc.origin_x    = origin_x;
        in_desc.origin_y    = origin_y;
        in_desc.col_step_x  = col_step_x;
        in_desc.col_step_y  = col_step_y;
        in_desc.row_step_x  = row_step_x;
        in_desc.row_step_y  = row_step_y;
    end

    spg_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_desc  (in_desc),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    spg_back
    #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .MAX_LIGHTS   (MAX_LIGHTS)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .light_index   (light_index),
        .dropped       (dropped),
        .last_of_panel (last_of_panel)
    );

endmodule

FILE: tb/sv/serpentine_panel_position_gen_tb.sv
`timescale 1ns / 100ps

module serpentine_panel_position_gen_tb;

    import spg_pkg::*;

    localparam int PANEL_WIDTH   = 8;
    localparam int PANEL_HEIGHT  = 8;
    localparam int MAX_LIGHTS    = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 100;
    localparam int TIMEOUT_NS    = 6000000;
    localparam int NUM_PHASES    = 6;
    localparam int SAT_PHASE     = 4;
    localparam int HOLD_PHASE    = 5;
    localparam int PHASE_PANELS  = 58;
    localparam int SAT_PANELS    = 72;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;
    typedef enum int {COORD_ANY, COORD_NEAR, COORD_EDGE} coord_kind_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        idx_t   light_index;
        logic   dropped;
        logic   last_of_panel;
    } light_t;

    class light_scoreboard;
        light_t pending_lights[$];
        cnt_t   light_count;
        cap_t   capacity;
        int     errors;
        int     reported;

        function new();
            light_count = '0;
            capacity    = CAP_RESET;
            errors      = 0;
            reported    = 0;
        endfunction

        // expand one panel into its serpentine run of lights
        function void expand_panel(desc_t d);
            coord_t row_x;
            coord_t row_y;
            coord_t px;
            coord_t py;
            cnt_t   usable;
            light_t l;
            usable = (capacity > cnt_t'(MAX_LIGHTS)) ? cnt_t'(MAX_LIGHTS) : cnt_t'(capacity);
            if (d.first_panel)
                light_count = '0;
            row_x = d.origin_x;
            row_y = d.origin_y;
            for (int r = 0; r < PANEL_HEIGHT; r++)
            begin
                if (r % 2 == 0)
                begin
                    px = row_x;
                    py = row_y;
                end
                else
                begin
                    px = row_x + coord_t'(PANEL_WIDTH - 1) * d.col_step_x + d.row_step_x;
                    py = row_y + coord_t'(PANEL_WIDTH - 1) * d.col_step_y + d.row_step_y;
                end
                for (int c = 0; c < PANEL_WIDTH; c++)
                begin
                    l.pos_x         = px;
                    l.pos_y         = py;
                    l.light_index   = (light_count > IDX_LIMIT) ? idx_t'(IDX_LIMIT)
                                                                : idx_t'(light_count);
                    l.dropped       = (light_count >= usable);
                    l.last_of_panel = (r == PANEL_HEIGHT - 1) && (c == PANEL_WIDTH - 1);
                    pending_lights.push_back(l);
                    if (light_count < cnt_t'(MAX_LIGHTS))
                        light_count++;
                    if (r % 2 == 0)
                    begin
                        px = px + d.col_step_x;
                        py = py + d.col_step_y;
                    end
                    else
                    begin
                        px = px - d.col_step_x;
                        py = py - d.col_step_y;
                    end
                end
                if (r % 2 == 1)
                begin
                    row_x = row_x + d.row_step_x + d.row_step_x;
                    row_y = row_y + d.row_step_y + d.row_step_y;
                end
            end
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (reported < MAX_REPORTS)
                $display("%0t: %s expected %h got %h", $time, field, want, got);
            reported++;
        endfunction

        function void check_light(light_t got);
            light_t want;
            if (pending_lights.size() == 0)
            begin
                errors++;
                if (reported < MAX_REPORTS)
                    $display("%0t: unexpected light, expected none got x=%h y=%h index=%0d",
                             $time, got.pos_x, got.pos_y, got.light_index);
                reported++;
                return;
            end
            want = pending_lights.pop_front();
            if (got.pos_x !== want.pos_x)
                report("pos_x", want.pos_x, got.pos_x);
            if (got.pos_y !== want.pos_y)
                report("pos_y", want.pos_y, got.pos_y);
            if (got.light_index !== want.light_index)
                report("light_index", 32'(want.light_index), 32'(got.light_index));
            if (got.dropped !== want.dropped)
                report("dropped", 32'(want.dropped), 32'(got.dropped));
            if (got.last_of_panel !== want.last_of_panel)
                report("last_of_panel", 32'(want.last_of_panel), 32'(got.last_of_panel));
        endfunction
    endclass

    logic   clk;
    logic   rst_n         = 1'b0;
    logic   cfg_we        = 1'b0;
    cap_t   cfg_wdata     = '0;
    logic   in_valid      = 1'b0;
    logic   in_stall;
    logic   first_panel   = 1'b0;
    coord_t origin_x      = '0;
    coord_t origin_y      = '0;
    coord_t col_step_x    = '0;
    coord_t col_step_y    = '0;
    coord_t row_step_x    = '0;
    coord_t row_step_y    = '0;
    logic   out_valid;
    logic   out_stall     = 1'b0;
    coord_t pos_x;
    coord_t pos_y;
    idx_t   light_index;
    logic   dropped;
    logic   last_of_panel;

    light_scoreboard sb;
    bit              hold_req   = 1'b0;
    int              burst_left = 0;

    serpentine_panel_position_gen #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .MAX_LIGHTS   (MAX_LIGHTS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_panel   (first_panel),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .col_step_x    (col_step_x),
        .col_step_y    (col_step_y),
        .row_step_x    (row_step_x),
        .row_step_y    (row_step_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .light_index   (light_index),
        .dropped       (dropped),
        .last_of_panel (last_of_panel)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.expand_panel('{first_panel, origin_x, origin_y, col_step_x, col_step_y,
                              row_step_x, row_step_y});
        if (rst_n && out_valid && !out_stall)
            sb.check_light('{pos_x, pos_y, light_index, dropped, last_of_panel});
    end

    // receiver: random stall segments, plus a long hold-off on request
    initial
    begin
        stall_mode_t mode;
        int          seg_left;
        int          hold_left;
        mode      = STALL_NONE;
        seg_left  = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (seg_left == 0)
            begin
                mode     = stall_mode_t'($urandom_range(0, 3));
                seg_left = $urandom_range(16, 200);
            end
            seg_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
                    default:      out_stall <= seg_left[0];
                endcase
            end
        end
    end

    function automatic coord_t rand_coord();
        coord_kind_t kind;
        kind = coord_kind_t'($urandom_range(0, 2));
        case (kind)
            COORD_NEAR: return coord_t'($urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
            COORD_EDGE:
            begin
                case ($urandom_range(0, 3))
                    0:       return coord_t'(32'h7FFF_FFFF);
                    1:       return coord_t'(32'h8000_0000);
                    2:       return coord_t'(32'h0000_0000);
                    default: return coord_t'(32'hFFFF_FFFF);
                endcase
            end
            default:    return coord_t'($urandom);
        endcase
    endfunction

    function automatic desc_t random_panel(bit first);
        desc_t d;
        d.first_panel = first;
        d.origin_x    = rand_coord();
        d.origin_y    = rand_coord();
        d.col_step_x  = rand_coord();
        d.col_step_y  = rand_coord();
        d.row_step_x  = rand_coord();
        d.row_step_y  = rand_coord();
        return d;
    endfunction

    function automatic desc_t panel(bit first, logic [31:0] ox, logic [31:0] oy,
                                    logic [31:0] ux, logic [31:0] uy,
                                    logic [31:0] vx, logic [31:0] vy);
        return '{first, ox, oy, ux, uy, vx, vy};
    endfunction

    task automatic offer_panel(input desc_t d, input bit back_to_back);
        int gap;
        if (!back_to_back && burst_left == 0)
        begin
            gap        = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4)
                                                     : $urandom_range(1, 100);
            burst_left = $urandom_range(1, 10);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        first_panel <= d.first_panel;
        origin_x    <= d.origin_x;
        origin_y    <= d.origin_y;
        col_step_x  <= d.col_step_x;
        col_step_y  <= d.col_step_y;
        row_step_x  <= d.row_step_x;
        row_step_y  <= d.row_step_y;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // hold the input idle until every light has come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_lights.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input cap_t value);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.capacity = value;
    endtask

    initial
    begin
        cap_t phase_caps[NUM_PHASES];
        int   count;
        bit   first;
        sb = new();
        phase_caps = '{13'd4096, 13'd100, 13'd4095, 13'd0, 13'd8191, 13'd2000};
        phase_caps[3] = cap_t'($urandom_range(0, 8191));
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        offer_panel(panel(1'b1, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000),
                    1'b0);
        offer_panel(panel(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 1'b0);
        offer_panel(panel(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0);
        offer_panel(panel(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000), 1'b0);
        offer_panel(panel(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_8000,
                          32'h0000_4000, 32'hFFFE_0000), 1'b0);
        offer_panel(panel(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                          32'h7FFF_FFFF, 32'h8000_0000), 1'b0);
        offer_panel(panel(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
        offer_panel(panel(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'h5555_5555, 32'hAAAA_AAAA), 1'b0);

        // every light dropped
        write_capacity(13'd0);
        offer_panel(random_panel(1'b1), 1'b0);
        offer_panel(random_panel(1'b0), 1'b0);
        // only the very first light kept
        write_capacity(13'd1);
        offer_panel(random_panel(1'b1), 1'b0);
        offer_panel(random_panel(1'b0), 1'b0);
        // capacity ends exactly on a panel boundary
        write_capacity(13'd64);
        offer_panel(random_panel(1'b1), 1'b0);
        offer_panel(random_panel(1'b0), 1'b0);
        // capacity above the list size
        write_capacity(13'd8191);
        offer_panel(random_panel(1'b1), 1'b0);
        offer_panel(random_panel(1'b0), 1'b0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(phase_caps[p]);
            count = (p == SAT_PHASE) ? SAT_PANELS : PHASE_PANELS;
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            for (int i = 0; i < count; i++)
            begin
                // saturation phase: no index clear after the first panel
                first = (i == 0) || (p != SAT_PHASE && $urandom_range(0, 7) == 0);
                offer_panel(random_panel(first), p == HOLD_PHASE && i < 12);
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending_lights.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
